FILE: rtl/tsw_pkg.sv
// Shared types and constants of the timestamp to wall-clock converter.
package tsw_pkg;

  localparam int unsigned STAMP_BITS  = 32;
  localparam int unsigned TICK_BITS   = 64;
  localparam int unsigned FREQ_BITS   = 32;
  localparam int unsigned SEC_BITS    = 32;
  localparam int unsigned NS_BITS     = 30;
  localparam int unsigned US_BITS     = 20;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [FREQ_BITS-1:0] TICK_FREQ_RESET = 32'd31250000;
  localparam logic [SEC_BITS-1:0]  SEC_MAX         = '1;
  localparam logic [NS_BITS-1:0]   NS_PER_SEC      = 30'd1000000000;
  localparam logic [NS_BITS:0]     NS_TWO_SEC      = 31'd2000000000;
  localparam logic [NS_BITS-1:0]   NS_MAX          = 30'd999999999;
  localparam logic [US_BITS-1:0]   US_PER_SEC      = 20'd1000000;
  localparam logic [US_BITS-1:0]   US_MAX          = 20'd999999;
  localparam logic [9:0]           NS_PER_US       = 10'd1000;
  localparam logic [8:0]           NS_HALF_US      = 9'd500;

  // Reciprocal of 1000 scaled by 2^40, rounded up; exact for inputs below 2^30.
  localparam logic [30:0]          US_RECIP        = 31'd1099511628;
  localparam int unsigned          US_SHIFT        = 40;

  typedef enum logic [0:0] {
    REQ_CONVERT = 1'b0,
    REQ_REBASE  = 1'b1
  } req_type_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DIV1,
    BK_MUL,
    BK_DIV2S,
    BK_DIV2,
    BK_SUM,
    BK_NORM,
    BK_USM,
    BK_FIN
  } back_state_e;

  typedef struct packed {
    logic [TICK_BITS-1:0] tics;
    logic [SEC_BITS-1:0]  wall_sec;
    logic [US_BITS-1:0]   wall_usec;
  } tsw_entry_t;

endpackage

FILE: rtl/nic_timestamp_to_wallclock.sv
// Top level of the NIC timestamp to wall-clock converter.
// A convert request extends the wrapping card stamp into a 64-bit tick count and
// returns the wall-clock time as seconds plus nanoseconds and as seconds plus
// rounded microseconds, both saturating; a rebase request returns nothing. A
// convert is done by two 64-step radix-2 divisions in one shared divider, and the
// next convert starts only once the previous result is loaded for output. The intake
// stage takes no new request while a convert waits to enter the two-entry queue
// in front of the divider, and a rebase is absorbed at once without waiting for
// conversions in flight.
module nic_timestamp_to_wallclock (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [31:0] stamp_i,
  input  logic [31:0] new_base_sec_i,
  input  logic [19:0] new_base_usec_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] seconds_o,
  output logic [29:0] nanoseconds_o,
  output logic [31:0] usec_seconds_o,
  output logic [19:0] microseconds_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_tick_freq_i
);
  import tsw_pkg::*;

  logic [FREQ_BITS-1:0] tick_freq_q;
  logic                 push;
  logic                 full;
  logic                 pop;
  logic                 empty;
  tsw_entry_t           front_entry;
  tsw_entry_t           back_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_freq_q <= TICK_FREQ_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tick_freq_q <= cfg_tick_freq_i;
    end
  end

  tsw_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .stamp_i         (stamp_i),
    .new_base_sec_i  (new_base_sec_i),
    .new_base_usec_i (new_base_usec_i),
    .push_o          (push),
    .entry_o         (front_entry),
    .full_i          (full)
  );

  tsw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (back_entry),
    .empty_o (empty)
  );

  tsw_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .freq_i         (tick_freq_q),
    .empty_i        (empty),
    .entry_i        (back_entry),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .seconds_o      (seconds_o),
    .nanoseconds_o  (nanoseconds_o),
    .usec_seconds_o (usec_seconds_o),
    .microseconds_o (microseconds_o)
  );

endmodule

FILE: rtl/tsw_front.sv
// Request intake: extends stamps into the running tick count and handles rebase.
module tsw_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               req_type_i,
  input  logic [31:0]                        stamp_i,
  input  logic [31:0]                        new_base_sec_i,
  input  logic [19:0]                        new_base_usec_i,
  output logic                               push_o,
  output tsw_pkg::tsw_entry_t                entry_o,
  input  logic                               full_i
);
  import tsw_pkg::*;

  logic [STAMP_BITS-1:0] last_q, last_d;
  logic [TICK_BITS-1:0]  running_q, running_d;
  logic [TICK_BITS-1:0]  base_q, base_d;
  logic [SEC_BITS-1:0]   wsec_q, wsec_d;
  logic [US_BITS-1:0]    wusec_q, wusec_d;
  logic                  pend_q, pend_d;
  logic [STAMP_BITS-1:0] st;
  logic [STAMP_BITS-1:0] delta;
  logic                  accept;

  assign st         = stamp_i[STAMP_BITS-1:0];
  assign delta      = st - last_q;
  assign in_ready_o = !pend_q;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = pend_q;

  assign entry_o.tics      = running_q - base_q;
  assign entry_o.wall_sec  = wsec_q;
  assign entry_o.wall_usec = wusec_q;

  always_comb begin
    last_d    = last_q;
    running_d = running_q;
    base_d    = base_q;
    wsec_d    = wsec_q;
    wusec_d   = wusec_q;
    pend_d    = pend_q && full_i;
    if (accept) begin
      if (req_type_i == REQ_REBASE) begin
        running_d = TICK_BITS'(st);
        base_d    = TICK_BITS'(st);
        wsec_d    = new_base_sec_i;
        wusec_d   = new_base_usec_i;
      end else begin
        running_d = running_q + TICK_BITS'(delta);
        last_d    = st;
        pend_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      running_q <= '0;
      base_q    <= '0;
      wsec_q    <= '0;
      wusec_q   <= '0;
      pend_q    <= 1'b0;
    end else begin
      last_q    <= last_d;
      running_q <= running_d;
      base_q    <= base_d;
      wsec_q    <= wsec_d;
      wusec_q   <= wusec_d;
      pend_q    <= pend_d;
    end
  end

endmodule

FILE: rtl/tsw_queue.sv
// Short queue of converted tick counts between the front and the back.
module tsw_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tsw_pkg::tsw_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output tsw_pkg::tsw_entry_t entry_o,
  output logic                empty_o
);
  import tsw_pkg::*;

  localparam int unsigned PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  tsw_entry_t            mem_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_q, wr_d;
  logic [PTR_BITS-1:0]   rd_q, rd_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = (cnt_q == CNT_BITS'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/tsw_div.sv
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
module tsw_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o,
  output logic [31:0] rem_o
);
  import tsw_pkg::*;

  localparam int unsigned DIV_STEPS = TICK_BITS;
  localparam int unsigned CNT_BITS  = $clog2(DIV_STEPS);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic [TICK_BITS-1:0]  quo_q;
  logic [FREQ_BITS-1:0]  rem_q;
  logic [FREQ_BITS-1:0]  den_q;
  logic [FREQ_BITS:0]    shifted;
  logic [FREQ_BITS:0]    diff;
  logic                  ge;

  assign shifted = {rem_q, quo_q[TICK_BITS-1]};
  assign ge      = (shifted >= {1'b0, den_q});
  assign diff    = shifted - {1'b0, den_q};
  assign done_o  = done_q;
  assign quo_o   = quo_q;
  assign rem_o   = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[TICK_BITS-2:0], ge};
      rem_q <= ge ? diff[FREQ_BITS-1:0] : shifted[FREQ_BITS-1:0];
    end
  end

endmodule

FILE: rtl/tsw_back.sv
// Conversion sequencer: divides elapsed ticks, adds the wall base and forms both outputs.
module tsw_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         freq_i,
  input  logic                empty_i,
  input  tsw_pkg::tsw_entry_t entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         seconds_o,
  output logic [29:0]         nanoseconds_o,
  output logic [31:0]         usec_seconds_o,
  output logic [19:0]         microseconds_o
);
  import tsw_pkg::*;

  back_state_e           state_q, state_d;
  logic                  div_start;
  logic [TICK_BITS-1:0]  div_num;
  logic [FREQ_BITS-1:0]  freq_eff;
  logic                  div_done;
  logic [TICK_BITS-1:0]  div_quo;
  logic [FREQ_BITS-1:0]  div_rem;

  logic [SEC_BITS-1:0]   wsec_q;
  logic [US_BITS-1:0]    wusec_q;
  logic [SEC_BITS-1:0]   whole_q;
  logic                  sat_q;
  logic [61:0]           prod_q;
  logic [NS_BITS-1:0]    frac_q;
  logic [NS_BITS:0]      ns_sum_q;
  logic [SEC_BITS:0]     sec_sum_q;
  logic [NS_BITS-1:0]    ns_q;
  logic [SEC_BITS-1:0]   total_q;
  logic [60:0]           usp_q;

  logic                  ge1;
  logic                  ge2;
  logic [SEC_BITS+1:0]   total_w;
  logic [US_BITS:0]      us_raw;
  logic                  us_carry;
  logic [SEC_BITS:0]     usec_sec_w;
  logic                  out_free;
  logic                  load_out;

  logic                  out_valid_q;
  logic [SEC_BITS-1:0]   seconds_q;
  logic [NS_BITS-1:0]    nanoseconds_q;
  logic [SEC_BITS-1:0]   usec_seconds_q;
  logic [US_BITS-1:0]    microseconds_q;

  assign freq_eff = (freq_i == '0) ? FREQ_BITS'(1) : freq_i;
  assign div_num  = (state_q == BK_IDLE) ? entry_i.tics : TICK_BITS'(prod_q);

  tsw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (freq_eff),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  assign ge2     = (ns_sum_q >= NS_TWO_SEC);
  assign ge1     = (ns_sum_q >= (NS_BITS + 1)'(NS_PER_SEC));
  assign total_w = (SEC_BITS + 2)'(sec_sum_q) + (SEC_BITS + 2)'({ge2, ge1 && !ge2});

  assign us_raw     = usp_q[US_SHIFT +: US_BITS + 1];
  assign us_carry   = (us_raw >= (US_BITS + 1)'(US_PER_SEC));
  assign usec_sec_w = (SEC_BITS + 1)'(total_q) + (SEC_BITS + 1)'(us_carry);

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    pop_o     = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          div_start = 1'b1;
          state_d   = BK_DIV1;
        end
      end
      BK_DIV1: begin
        if (div_done) begin
          state_d = BK_MUL;
        end
      end
      BK_MUL:   state_d = BK_DIV2S;
      BK_DIV2S: begin
        div_start = 1'b1;
        state_d   = BK_DIV2;
      end
      BK_DIV2: begin
        if (div_done) begin
          state_d = BK_SUM;
        end
      end
      BK_SUM:  state_d = BK_NORM;
      BK_NORM: state_d = BK_USM;
      BK_USM:  state_d = BK_FIN;
      BK_FIN: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        wsec_q  <= entry_i.wall_sec;
        wusec_q <= entry_i.wall_usec;
      end
      BK_DIV1: begin
        if (div_done) begin
          whole_q <= div_quo[SEC_BITS-1:0];
          sat_q   <= |div_quo[TICK_BITS-1:SEC_BITS];
        end
      end
      BK_MUL: begin
        prod_q <= 62'(NS_PER_SEC) * 62'(div_rem);
      end
      BK_DIV2: begin
        if (div_done) begin
          frac_q <= div_quo[NS_BITS-1:0];
        end
      end
      BK_SUM: begin
        ns_sum_q  <= (NS_BITS + 1)'(frac_q) + (NS_BITS + 1)'(wusec_q) * (NS_BITS + 1)'(NS_PER_US);
        sec_sum_q <= (SEC_BITS + 1)'(whole_q) + (SEC_BITS + 1)'(wsec_q);
      end
      BK_NORM: begin
        if (ge2) begin
          ns_q <= NS_BITS'(ns_sum_q - NS_TWO_SEC);
        end else if (ge1) begin
          ns_q <= NS_BITS'(ns_sum_q - (NS_BITS + 1)'(NS_PER_SEC));
        end else begin
          ns_q <= ns_sum_q[NS_BITS-1:0];
        end
        total_q <= total_w[SEC_BITS-1:0];
        sat_q   <= sat_q || (total_w[SEC_BITS+1:SEC_BITS] != '0);
      end
      BK_USM: begin
        usp_q <= 61'(ns_q + NS_BITS'(NS_HALF_US)) * 61'(US_RECIP);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (sat_q) begin
        seconds_q      <= SEC_MAX;
        nanoseconds_q  <= NS_MAX;
        usec_seconds_q <= SEC_MAX;
        microseconds_q <= US_MAX;
      end else begin
        seconds_q     <= total_q;
        nanoseconds_q <= ns_q;
        if (usec_sec_w[SEC_BITS]) begin
          usec_seconds_q <= SEC_MAX;
          microseconds_q <= US_MAX;
        end else begin
          usec_seconds_q <= usec_sec_w[SEC_BITS-1:0];
          microseconds_q <= us_carry ? US_BITS'(us_raw - (US_BITS + 1)'(US_PER_SEC))
                                     : us_raw[US_BITS-1:0];
        end
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign seconds_o      = seconds_q;
  assign nanoseconds_o  = nanoseconds_q;
  assign usec_seconds_o = usec_seconds_q;
  assign microseconds_o = microseconds_q;

endmodule

FILE: rtl/tsw_checker.sv
// Port-level checks of the converter and their attachment to the top level.
module tsw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] seconds_o,
  input logic [29:0] nanoseconds_o,
  input logic [31:0] usec_seconds_o,
  input logic [19:0] microseconds_o
);
  import tsw_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Result dropped before it was taken.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(seconds_o) && $stable(nanoseconds_o)
      && $stable(usec_seconds_o) && $stable(microseconds_o))
    else $error("Result changed while stalled.");

  a_ns_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> nanoseconds_o <= NS_MAX && microseconds_o <= US_MAX)
    else $error("Fraction field out of range.");

  a_usec_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> usec_seconds_o == seconds_o || (usec_seconds_o == seconds_o + 32'd1
      && microseconds_o == '0) || (usec_seconds_o == SEC_MAX && microseconds_o == US_MAX))
    else $error("Microsecond form disagrees with nanosecond form.");

  a_sat_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seconds_o == SEC_MAX && nanoseconds_o == NS_MAX
      |-> usec_seconds_o == SEC_MAX && microseconds_o == US_MAX)
    else $error("Saturation not applied to the microsecond form.");

endmodule

bind nic_timestamp_to_wallclock tsw_checker u_tsw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .seconds_o      (seconds_o),
  .nanoseconds_o  (nanoseconds_o),
  .usec_seconds_o (usec_seconds_o),
  .microseconds_o (microseconds_o)
);
